// File: src/vfv_pkg.sv
// ============================================================================
// vfv_pkg
// shared types and constants of the voxel face visibility unit
// ============================================================================
`default_nettype none

package vfv_pkg;

    localparam int COORD_W = 8;
    localparam int ID_W    = 8;
    localparam int FACE_N  = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int FACE_POS_X = 0;
    localparam int FACE_NEG_X = 1;
    localparam int FACE_POS_Y = 2;
    localparam int FACE_NEG_Y = 3;
    localparam int FACE_POS_Z = 4;
    localparam int FACE_NEG_Z = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_WRITE,
        ST_READ,
        ST_RESULT
    } vfv_state_t;

    typedef struct packed {
        logic              in_range;
        logic [ID_W-1:0]   cell_id;
        logic [FACE_N-1:0] face_mask;
    } vfv_result_t;

endpackage

`default_nettype wire

// File: src/vfv_cell_mem.sv
// ============================================================================
// vfv_cell_mem
// block id store: one write port, two read ports, registered read data
// ============================================================================
`default_nettype none

module vfv_cell_mem #(
    parameter int DEPTH = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [$clog2(DEPTH)-1:0]    waddr,
    input  wire logic [vfv_pkg::ID_W-1:0]    wdata,
    input  wire logic [$clog2(DEPTH)-1:0]    raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]    raddr_b,
    output logic      [vfv_pkg::ID_W-1:0]    rdata_a,
    output logic      [vfv_pkg::ID_W-1:0]    rdata_b
);

    logic [vfv_pkg::ID_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// File: src/vfv_seq.sv
// ============================================================================
// vfv_seq
// item sequencer: address generation, store access and face mask collection
// ============================================================================
`default_nettype none

module vfv_seq #(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16,
    parameter int GRID_Z = 16
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            item_valid,
    output logic                                                 item_ready,
    input  wire logic                                            item_op,
    input  wire logic [vfv_pkg::COORD_W-1:0]                     item_x,
    input  wire logic [vfv_pkg::COORD_W-1:0]                     item_y,
    input  wire logic [vfv_pkg::COORD_W-1:0]                     item_z,
    input  wire logic [vfv_pkg::ID_W-1:0]                        item_id,
    output logic                                                 mem_we,
    output logic [$clog2(GRID_X*GRID_Y*GRID_Z)-1:0]              mem_waddr,
    output logic [vfv_pkg::ID_W-1:0]                             mem_wdata,
    output logic [$clog2(GRID_X*GRID_Y*GRID_Z)-1:0]              mem_raddr_a,
    output logic [$clog2(GRID_X*GRID_Y*GRID_Z)-1:0]              mem_raddr_b,
    input  wire logic [vfv_pkg::ID_W-1:0]                        mem_rdata_a,
    input  wire logic [vfv_pkg::ID_W-1:0]                        mem_rdata_b,
    output logic                                                 res_valid,
    input  wire logic                                            res_ready,
    output vfv_pkg::vfv_result_t                                 res
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] STRIDE_X = AW'(1);
    localparam logic [AW-1:0] STRIDE_Z = AW'(GRID_X);
    localparam logic [AW-1:0] STRIDE_Y = AW'(GRID_X * GRID_Z);

    vfv_pkg::vfv_state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    logic                          op_reg;
    logic [vfv_pkg::COORD_W-1:0]   x_reg, y_reg, z_reg;
    logic [vfv_pkg::ID_W-1:0]      id_reg;
    logic                          in_range_reg, in_range_next;
    logic [AW-1:0]                 base_reg, base_next;
    logic [vfv_pkg::FACE_N-1:0]    edge_reg, edge_next;
    logic [vfv_pkg::ID_W-1:0]      cell_reg, cell_next;
    logic [vfv_pkg::FACE_N-1:0]    face_reg, face_next;

    logic [AW-1:0] nbr_addr [vfv_pkg::FACE_N];
    logic [1:0]    pair_col;
    logic          accept;

    assign accept = item_valid && item_ready;

    // neighbour addresses, pinned to the centre where the face points out of the grid
    always_comb
    begin
        nbr_addr[vfv_pkg::FACE_POS_X] = edge_reg[vfv_pkg::FACE_POS_X] ? base_reg
                                                                       : base_reg + STRIDE_X;
        nbr_addr[vfv_pkg::FACE_NEG_X] = edge_reg[vfv_pkg::FACE_NEG_X] ? base_reg
                                                                       : base_reg - STRIDE_X;
        nbr_addr[vfv_pkg::FACE_POS_Y] = edge_reg[vfv_pkg::FACE_POS_Y] ? base_reg
                                                                       : base_reg + STRIDE_Y;
        nbr_addr[vfv_pkg::FACE_NEG_Y] = edge_reg[vfv_pkg::FACE_NEG_Y] ? base_reg
                                                                       : base_reg - STRIDE_Y;
        nbr_addr[vfv_pkg::FACE_POS_Z] = edge_reg[vfv_pkg::FACE_POS_Z] ? base_reg
                                                                       : base_reg + STRIDE_Z;
        nbr_addr[vfv_pkg::FACE_NEG_Z] = edge_reg[vfv_pkg::FACE_NEG_Z] ? base_reg
                                                                       : base_reg - STRIDE_Z;
    end

    assign pair_col = 2'(cnt_reg - 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vfv_pkg::ST_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= item_op;
            x_reg  <= item_x;
            y_reg  <= item_y;
            z_reg  <= item_z;
            id_reg <= item_id;
        end
        in_range_reg <= in_range_next;
        base_reg     <= base_next;
        edge_reg     <= edge_next;
        cell_reg     <= cell_next;
        face_reg     <= face_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        in_range_next = in_range_reg;
        base_next     = base_reg;
        edge_next     = edge_reg;
        cell_next     = cell_reg;
        face_next     = face_reg;
        item_ready    = 1'b0;
        res_valid     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = base_reg;
        mem_wdata     = id_reg;
        mem_raddr_a   = base_reg;
        mem_raddr_b   = base_reg;

        unique case (state_reg)
            vfv_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    state_next = vfv_pkg::ST_ADDR;
                end
            end
            vfv_pkg::ST_ADDR:
            begin
                in_range_next = (x_reg < vfv_pkg::COORD_W'(GRID_X))
                             && (y_reg < vfv_pkg::COORD_W'(GRID_Y))
                             && (z_reg < vfv_pkg::COORD_W'(GRID_Z));
                base_next = (AW'(y_reg) * AW'(GRID_Z) + AW'(z_reg)) * AW'(GRID_X)
                          + AW'(x_reg);
                edge_next[vfv_pkg::FACE_POS_X] = x_reg == vfv_pkg::COORD_W'(GRID_X - 1);
                edge_next[vfv_pkg::FACE_NEG_X] = x_reg == '0;
                edge_next[vfv_pkg::FACE_POS_Y] = y_reg == vfv_pkg::COORD_W'(GRID_Y - 1);
                edge_next[vfv_pkg::FACE_NEG_Y] = y_reg == '0;
                edge_next[vfv_pkg::FACE_POS_Z] = z_reg == vfv_pkg::COORD_W'(GRID_Z - 1);
                edge_next[vfv_pkg::FACE_NEG_Z] = z_reg == '0;
                cell_next = '0;
                face_next = '0;
                cnt_next  = 3'd0;
                if (op_reg == vfv_pkg::OP_WRITE)
                begin
                    state_next = vfv_pkg::ST_WRITE;
                end
                else if (in_range_next)
                begin
                    state_next = vfv_pkg::ST_READ;
                end
                else
                begin
                    state_next = vfv_pkg::ST_RESULT;
                end
            end
            vfv_pkg::ST_WRITE:
            begin
                mem_we = in_range_reg;
                if (in_range_reg)
                begin
                    cell_next = id_reg;
                end
                state_next = vfv_pkg::ST_RESULT;
            end
            vfv_pkg::ST_READ:
            begin
                // issue pair cnt_reg, collect the pair issued in the cycle before
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        mem_raddr_a = base_reg;
                        mem_raddr_b = nbr_addr[vfv_pkg::FACE_POS_X];
                    end
                    2'd1:
                    begin
                        mem_raddr_a = nbr_addr[vfv_pkg::FACE_NEG_X];
                        mem_raddr_b = nbr_addr[vfv_pkg::FACE_POS_Y];
                    end
                    2'd2:
                    begin
                        mem_raddr_a = nbr_addr[vfv_pkg::FACE_NEG_Y];
                        mem_raddr_b = nbr_addr[vfv_pkg::FACE_POS_Z];
                    end
                    default:
                    begin
                        mem_raddr_a = nbr_addr[vfv_pkg::FACE_NEG_Z];
                        mem_raddr_b = base_reg;
                    end
                endcase
                if (cnt_reg != 3'd0)
                begin
                    case (pair_col)
                        2'd0:
                        begin
                            cell_next = mem_rdata_a;
                            face_next[vfv_pkg::FACE_POS_X] = edge_reg[vfv_pkg::FACE_POS_X]
                                                          || (mem_rdata_b == '0);
                        end
                        2'd1:
                        begin
                            face_next[vfv_pkg::FACE_NEG_X] = edge_reg[vfv_pkg::FACE_NEG_X]
                                                          || (mem_rdata_a == '0);
                            face_next[vfv_pkg::FACE_POS_Y] = edge_reg[vfv_pkg::FACE_POS_Y]
                                                          || (mem_rdata_b == '0);
                        end
                        2'd2:
                        begin
                            face_next[vfv_pkg::FACE_NEG_Y] = edge_reg[vfv_pkg::FACE_NEG_Y]
                                                          || (mem_rdata_a == '0);
                            face_next[vfv_pkg::FACE_POS_Z] = edge_reg[vfv_pkg::FACE_POS_Z]
                                                          || (mem_rdata_b == '0);
                        end
                        default:
                        begin
                            face_next[vfv_pkg::FACE_NEG_Z] = edge_reg[vfv_pkg::FACE_NEG_Z]
                                                          || (mem_rdata_a == '0);
                        end
                    endcase
                end
                if (cnt_reg == 3'd4)
                begin
                    state_next = vfv_pkg::ST_RESULT;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            vfv_pkg::ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = vfv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vfv_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.in_range  = in_range_reg;
    assign res.cell_id   = cell_reg;
    assign res.face_mask = (cell_reg != '0) ? face_reg : '0;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !item_ready)
        else $error("item accepted while a result is pending");

    a_write_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> res_valid)
        else $error("store write not followed by its result");

    a_out_of_range_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.in_range |-> res.cell_id == '0 && res.face_mask == '0)
        else $error("out of range item reports a non-empty cell");

    a_write_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && op_reg == vfv_pkg::OP_WRITE |-> res.face_mask == '0)
        else $error("write reports a face mask");

endmodule

`default_nettype wire

// File: src/voxel_face_visibility_unit.sv
// ============================================================================
// voxel_face_visibility_unit
// one chunk of voxel block ids with write and visible-face query beats
// ============================================================================
// input beats carry an op in s_tuser: write places block_id at (x, y, z),
// query returns the id there and, for a non-empty cell, a mask of faces
// whose neighbour is empty or outside the grid. every input beat gives
// exactly one output beat; m_tuser is the in-range flag, a write outside
// the grid is dropped. one item is worked at a time: a write goes through
// the address and write states, an out-of-range query straight to the
// result; an in-range query reads the store seven times, the cell and its
// six neighbours, through its two read ports in four read slots.
// the output beat is held in a register, so a new input beat is taken
// while the previous output beat still waits; a stalled receiver holds
// the next result in the sequencer and blocks further input.
// reset clears the control state only; the store contents are undefined
// until written and no clearing pass follows reset.
// ============================================================================
`default_nettype none

module voxel_face_visibility_unit #(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16,
    parameter int GRID_Z = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // pos_x, pos_y, pos_z, block_id
    input  wire logic        s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // cell_id, face_mask, zero pad
    output logic             m_tuser    // in_range
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(DEPTH);

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [vfv_pkg::ID_W-1:0]     mem_wdata;
    logic [AW-1:0]                mem_raddr_a;
    logic [AW-1:0]                mem_raddr_b;
    logic [vfv_pkg::ID_W-1:0]     mem_rdata_a;
    logic [vfv_pkg::ID_W-1:0]     mem_rdata_b;

    logic                  res_valid;
    logic                  res_ready;
    vfv_pkg::vfv_result_t  res;

    logic                  m_valid_reg;
    vfv_pkg::vfv_result_t  m_data_reg;

    vfv_seq #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .item_op     (s_tuser),
        .item_x      (s_tdata[7:0]),
        .item_y      (s_tdata[15:8]),
        .item_z      (s_tdata[23:16]),
        .item_id     (s_tdata[31:24]),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    vfv_cell_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // output beat register
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.in_range;
    assign m_tdata  = {2'b00, m_data_reg.face_mask, m_data_reg.cell_id};

endmodule

`default_nettype wire

// File: tb/tb_voxel_face_visibility_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_voxel_face_visibility_unit
// self-checking bench for the voxel face visibility unit
// ============================================================================
// write and query beats go in on the slave side. A local copy of the chunk
// predicts each output beat: the in-range flag, the stored id and the
// visible-face mask. Directed beats cover the grid limits, out-of-range
// coordinates, corner cells and empty cells. Random beats follow,
// grouped in a box that moves over the grid. An in-range query goes out
// only when the cell and all of its in-grid neighbours have been written.
// The sender runs in bursts with gaps. The receiver stalls on its own
// pattern, and holds off once for a long stretch so that the unit backs up.
// ============================================================================

module tb_voxel_face_visibility_unit;

    localparam int GX          = 16;
    localparam int GY          = 16;
    localparam int GZ          = 16;
    localparam int CELLS       = GX * GY * GZ;
    localparam int BOX         = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 40;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    logic [vfv_pkg::ID_W-1:0] voxel_ids [CELLS];
    bit                       voxel_written [CELLS];
    vfv_pkg::vfv_result_t     pending_results [$];
    vfv_pkg::vfv_result_t     head_result;

    int mismatch_count   = 0;
    int burst_left       = 0;
    bit hold_off_req     = 1'b0;
    int ready_mode       = 0;
    int ready_phase_left = 0;
    int box_x, box_y, box_z;

    voxel_face_visibility_unit #(
        .GRID_X (GX),
        .GRID_Y (GY),
        .GRID_Z (GZ)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // pos_x, pos_y, pos_z, block_id
        .s_tuser  (s_tuser),    // op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // cell_id, face_mask, zero pad
        .m_tuser  (m_tuser)     // in_range
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int voxel_addr(int x, int y, int z);
        return (y * GZ + z) * GX + x;
    endfunction

    function automatic bit in_grid(int x, int y, int z);
        return x >= 0 && x < GX && y >= 0 && y < GY && z >= 0 && z < GZ;
    endfunction

    function automatic logic [vfv_pkg::ID_W-1:0] id_at(int x, int y, int z);
        if (!in_grid(x, y, z))
            return '0;
        return voxel_ids[voxel_addr(x, y, z)];
    endfunction

    // cell and every in-grid neighbour hold a written id
    function automatic bit query_safe(int x, int y, int z);
        int dx [6] = '{1, -1, 0, 0, 0, 0};
        int dy [6] = '{0, 0, 1, -1, 0, 0};
        int dz [6] = '{0, 0, 0, 0, 1, -1};
        if (!voxel_written[voxel_addr(x, y, z)])
            return 1'b0;
        for (int f = 0; f < 6; f++)
            if (in_grid(x + dx[f], y + dy[f], z + dz[f]) &&
                !voxel_written[voxel_addr(x + dx[f], y + dy[f], z + dz[f])])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic vfv_pkg::vfv_result_t predict_voxel_beat(logic op, int x, int y,
                                                                int z,
                                                                logic [vfv_pkg::ID_W-1:0] id);
        vfv_pkg::vfv_result_t r;
        r = '0;
        if (!in_grid(x, y, z))
            return r;
        r.in_range = 1'b1;
        if (op == vfv_pkg::OP_WRITE)
        begin
            voxel_ids[voxel_addr(x, y, z)]     = id;
            voxel_written[voxel_addr(x, y, z)] = 1'b1;
            r.cell_id = id;
        end
        else
        begin
            r.cell_id = id_at(x, y, z);
            if (r.cell_id != '0)
            begin
                r.face_mask[vfv_pkg::FACE_POS_X] = id_at(x + 1, y, z) == '0;
                r.face_mask[vfv_pkg::FACE_NEG_X] = id_at(x - 1, y, z) == '0;
                r.face_mask[vfv_pkg::FACE_POS_Y] = id_at(x, y + 1, z) == '0;
                r.face_mask[vfv_pkg::FACE_NEG_Y] = id_at(x, y - 1, z) == '0;
                r.face_mask[vfv_pkg::FACE_POS_Z] = id_at(x, y, z + 1) == '0;
                r.face_mask[vfv_pkg::FACE_NEG_Z] = id_at(x, y, z - 1) == '0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        if (mismatch_count < MAX_PRINTS)
            $display("error at %0t: %s want %0h got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    task automatic push_voxel_beat(logic op, int x, int y, int z, int id);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {id[7:0], z[7:0], y[7:0], x[7:0]};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_voxel_beat(op, x, y, z, id[7:0]));
    endtask

    function automatic int pick_block_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 0;
        if (r == 4)
            return 255;
        return $urandom_range(1, 255);
    endfunction

    function automatic int pick_anchor(int n);
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return n - BOX;
            default: return $urandom_range(0, n - BOX);
        endcase
    endfunction

    task automatic send_random_item();
        int  r;
        int  x, y, z;
        int  sel;
        bit  found;
        r = $urandom_range(0, 99);
        found = 1'b0;
        if (r >= 38 && r < 80)
        begin
            for (int t = 0; t < 8 && !found; t++)
            begin
                x = box_x + $urandom_range(0, BOX - 1);
                y = box_y + $urandom_range(0, BOX - 1);
                z = box_z + $urandom_range(0, BOX - 1);
                found = query_safe(x, y, z);
            end
            if (found)
                push_voxel_beat(vfv_pkg::OP_QUERY, x, y, z, $urandom_range(0, 255));
        end
        if (found)
            return;
        if (r >= 80 && r < 90)
        begin
            x = $urandom_range(0, GX - 1);
            y = $urandom_range(0, GY - 1);
            z = $urandom_range(0, GZ - 1);
            sel = $urandom_range(1, 7);
            if (sel[0])
                x = $urandom_range(GX, 255);
            if (sel[1])
                y = $urandom_range(GY, 255);
            if (sel[2])
                z = $urandom_range(GZ, 255);
            push_voxel_beat($urandom_range(0, 1) ? vfv_pkg::OP_QUERY : vfv_pkg::OP_WRITE,
                            x, y, z, $urandom_range(0, 255));
        end
        else if (r >= 90)
            push_voxel_beat(vfv_pkg::OP_WRITE, $urandom_range(0, GX - 1),
                            $urandom_range(0, GY - 1), $urandom_range(0, GZ - 1),
                            pick_block_id());
        else
            push_voxel_beat(vfv_pkg::OP_WRITE, box_x + $urandom_range(0, BOX - 1),
                            box_y + $urandom_range(0, BOX - 1),
                            box_z + $urandom_range(0, BOX - 1), pick_block_id());
    endtask

    task automatic test_out_of_range();
        push_voxel_beat(vfv_pkg::OP_WRITE, GX, 0, 0, 8'h5A);
        push_voxel_beat(vfv_pkg::OP_WRITE, 0, 255, 0, 8'hFF);
        push_voxel_beat(vfv_pkg::OP_WRITE, 0, 0, GZ, 8'h01);
        push_voxel_beat(vfv_pkg::OP_QUERY, 255, 255, 255, 8'hFF);
        push_voxel_beat(vfv_pkg::OP_QUERY, GX - 1, GY, GZ - 1, 8'h00);
    endtask

    task automatic test_origin_corner();
        push_voxel_beat(vfv_pkg::OP_WRITE, 0, 0, 0, 8'h01);
        push_voxel_beat(vfv_pkg::OP_WRITE, 1, 0, 0, 8'h00);
        push_voxel_beat(vfv_pkg::OP_WRITE, 0, 1, 0, 8'h00);
        push_voxel_beat(vfv_pkg::OP_WRITE, 0, 0, 1, 8'h00);
        push_voxel_beat(vfv_pkg::OP_QUERY, 0, 0, 0, 8'hFF);
        // neighbours filled, the mask must drop the covered faces
        push_voxel_beat(vfv_pkg::OP_WRITE, 1, 0, 0, 8'h80);
        push_voxel_beat(vfv_pkg::OP_WRITE, 0, 1, 0, 8'hFF);
        push_voxel_beat(vfv_pkg::OP_WRITE, 0, 0, 1, 8'h55);
        push_voxel_beat(vfv_pkg::OP_QUERY, 0, 0, 0, 8'h00);
    endtask

    task automatic test_far_corner_empty();
        push_voxel_beat(vfv_pkg::OP_WRITE, GX - 1, GY - 1, GZ - 1, 8'h00);
        push_voxel_beat(vfv_pkg::OP_WRITE, GX - 2, GY - 1, GZ - 1, 8'h03);
        push_voxel_beat(vfv_pkg::OP_WRITE, GX - 1, GY - 2, GZ - 1, 8'h03);
        push_voxel_beat(vfv_pkg::OP_WRITE, GX - 1, GY - 1, GZ - 2, 8'h03);
        push_voxel_beat(vfv_pkg::OP_QUERY, GX - 1, GY - 1, GZ - 1, 8'hFF);
        push_voxel_beat(vfv_pkg::OP_WRITE, GX - 1, GY - 1, GZ - 1, 8'hAA);
        push_voxel_beat(vfv_pkg::OP_QUERY, GX - 1, GY - 1, GZ - 1, 8'h00);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 120 == 0)
            begin
                box_x = pick_anchor(GX);
                box_y = pick_anchor(GY);
                box_z = pick_anchor(GZ);
            end
            send_random_item();
        end
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (24) send_random_item();
    endtask

    // receiver: random stall pattern, with one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (ready_phase_left == 0)
                begin
                    ready_mode       = $urandom_range(0, 3);
                    ready_phase_left = $urandom_range(16, 96);
                end
                ready_phase_left--;
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("beat with nothing pending", 0, {m_tuser, m_tdata});
            else
            begin
                head_result = pending_results.pop_front();
                if (m_tuser !== head_result.in_range)
                    report_mismatch("in_range", head_result.in_range, m_tuser);
                if (m_tdata[7:0] !== head_result.cell_id)
                    report_mismatch("cell_id", head_result.cell_id, m_tdata[7:0]);
                if (m_tdata[13:8] !== head_result.face_mask)
                    report_mismatch("face_mask", head_result.face_mask, m_tdata[13:8]);
                if (m_tdata[15:14] !== 2'b00)
                    report_mismatch("tdata pad", 0, m_tdata[15:14]);
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("voxel_face_visibility_unit: mismatch");
        $finish;
    end

    initial
    begin
        int waited;
        waited = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_out_of_range();
        test_origin_corner();
        test_far_corner_empty();
        test_random(700);
        test_backpressure();
        test_random(626);

        s_tvalid <= 1'b0;
        while (pending_results.size() > 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() > 0)
            report_mismatch("beats never delivered", pending_results.size(), 0);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("voxel_face_visibility_unit: match");
        else
            $display("voxel_face_visibility_unit: mismatch");
        $finish;
    end

endmodule
